[hw/rtl/ham_pkg.sv]
package ham_pkg;

   // signed weight width and the widths of the stream payloads
   localparam int WEIGHT_W = 6;
   localparam int PAT_W    = 64;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;

   typedef logic signed [WEIGHT_W-1:0] weight_type;

   // request kinds
   localparam logic MODE_STORE  = 1'b0;
   localparam logic MODE_RECALL = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_STORED  = 3'd0;
   localparam logic [2:0] STATUS_PRESENT = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_MATCH   = 3'd3;
   localparam logic [2:0] STATUS_NOMATCH = 3'd4;

   // register indexes and reset values
   localparam logic REG_MAX_ITER = 1'b0;
   localparam logic [7:0] MAX_ITER_RESET = 8'd10;

endpackage

[hw/rtl/hopfield_associative_memory.sv]
// Channel  Direction  Payload
// req      in         tuser: mode; tdata: pattern[63:0], palatability[64]
// rsp      out        tuser: status; tdata: slot[3:0], palatability_out[4],
//                     recalled_pattern[68:5]
// csr      in         APB write/read of max_iterations at byte address 0
//
// Store: a pattern search, then, for a new pattern with room, a read-modify-write of
// every weight row; recall: each update pass reads one weight row per cycle, with
// up to max_iterations+2 passes, then a search.
// One request is in work at a time; the output register lets the next request
// in while a response waits. Reset clears the weight row valid bits at once.
module hopfield_associative_memory #(
   parameter int NEURONS      = 64,
   parameter int MAX_PATTERNS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [ham_pkg::REQ_TDATA_W-1:0] req_tdata, // pattern, palatability
   input  logic        req_tuser,                     // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [ham_pkg::RSP_TDATA_W-1:0] rsp_tdata, // slot, palatability_out, recalled_pattern
   output logic [2:0]  rsp_tuser,                     // status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int WW    = ham_pkg::WEIGHT_W;
   localparam int ROW_W = NEURONS * WW;
   localparam int RW    = $clog2(NEURONS);
   localparam int RCW   = $clog2(NEURONS + 1);
   localparam int CW    = $clog2(MAX_PATTERNS + 1);
   localparam int SW    = MAX_PATTERNS > 1 ? $clog2(MAX_PATTERNS) : 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_TRAIN  = 6'b000100,
      S_PASS   = 6'b001000,
      S_PCHECK = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         max_iter_ff, max_iter_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               mode_ff, mode_in;
   logic               taste_ff, taste_in;
   logic [NEURONS-1:0] y_ff, y_in;
   logic [NEURONS-1:0] nxt_ff, nxt_in;
   logic [8:0]         itr_ff, itr_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [SW-1:0]      chk_slot_ff, chk_slot_in;
   logic               found_ff, found_in;
   logic [SW-1:0]      hit_slot_ff, hit_slot_in;
   logic               hit_taste_ff, hit_taste_in;
   logic [RCW-1:0]     row_ff, row_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [RW-1:0]      pend_idx_ff, pend_idx_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [3:0]         res_slot_ff, res_slot_in;
   logic               res_pal_ff, res_pal_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [3:0]         rsp_slot_ff, rsp_slot_in;
   logic               rsp_pal_ff, rsp_pal_in;
   logic [NEURONS-1:0] rsp_pat_ff, rsp_pat_in;

   logic               csr_write;
   logic               accept;
   logic               wm_rd_en;
   logic [ROW_W-1:0]   wm_rd_row;
   logic               wm_wr_en;
   logic [ROW_W-1:0]   wm_wr_row;
   logic               pm_rd_en;
   logic [NEURONS:0]   pm_rd_data;
   logic               pm_wr_en;
   logic               rs_in_valid;
   logic               rs_out_valid;
   logic [RW-1:0]      rs_out_idx;
   logic               rs_out_bit;
   logic               search_done;
   logic               train_done;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == ham_pkg::REG_MAX_ITER) ? {24'd0, max_iter_ff} : 32'd0;

   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid & req_tready;

   // memory control
   assign wm_rd_en    = (state_ff == S_TRAIN || state_ff == S_PASS) &&
                        row_ff < RCW'(NEURONS);
   assign wm_wr_en    = state_ff == S_TRAIN && pend_valid_ff;
   assign rs_in_valid = state_ff == S_PASS && pend_valid_ff;
   assign pm_rd_en    = state_ff == S_SEARCH && idx_ff < count_ff;
   assign search_done = state_ff == S_SEARCH && idx_ff >= count_ff && !chk_valid_ff;
   assign train_done  = row_ff == RCW'(NEURONS) && !pend_valid_ff;
   assign pm_wr_en    = search_done && mode_ff == ham_pkg::MODE_STORE && !found_ff &&
                        count_ff < CW'(MAX_PATTERNS);

   // outer product increment of the row in flight; diagonal kept
   always_comb begin
      for (int j = 0; j < NEURONS; j++) begin
         if (RW'(j) == pend_idx_ff)
            wm_wr_row[j*WW +: WW] = wm_rd_row[j*WW +: WW];
         else if (y_ff[pend_idx_ff] == y_ff[j])
            wm_wr_row[j*WW +: WW] = wm_rd_row[j*WW +: WW] + WW'(1);
         else
            wm_wr_row[j*WW +: WW] = wm_rd_row[j*WW +: WW] - WW'(1);
      end
   end

   // control sequencer
   always_comb begin
      state_in      = state_ff;
      max_iter_in   = max_iter_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      taste_in      = taste_ff;
      y_in          = y_ff;
      nxt_in        = nxt_ff;
      itr_in        = itr_ff;
      idx_in        = idx_ff;
      chk_valid_in  = pm_rd_en;
      chk_slot_in   = idx_ff[SW-1:0];
      found_in      = found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_taste_in  = hit_taste_ff;
      row_in        = row_ff;
      pend_valid_in = wm_rd_en;
      pend_idx_in   = row_ff[RW-1:0];
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pal_in    = res_pal_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pal_in    = rsp_pal_ff;
      rsp_pat_in    = rsp_pat_ff;

      if (csr_write && csr_paddr[2] == ham_pkg::REG_MAX_ITER)
         max_iter_in = csr_pwdata[7:0];

      if (chk_valid_ff && pm_rd_data[NEURONS-1:0] == y_ff) begin
         found_in     = 1'b1;
         hit_slot_in  = chk_slot_ff;
         hit_taste_in = pm_rd_data[NEURONS];
      end
      if (wm_rd_en) row_in = row_ff + RCW'(1);
      if (pm_rd_en) idx_in = idx_ff + CW'(1);
      if (rs_out_valid) nxt_in[rs_out_idx] = rs_out_bit;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_tuser;
               taste_in = req_tdata[ham_pkg::PAT_W];
               y_in     = req_tdata[NEURONS-1:0];
               itr_in   = '0;
               row_in   = '0;
               nxt_in   = '0;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = (req_tuser == ham_pkg::MODE_RECALL) ? S_PASS : S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (search_done) begin
               state_in = S_DONE;
               if (mode_ff == ham_pkg::MODE_RECALL) begin
                  res_status_in = found_ff ? ham_pkg::STATUS_MATCH : ham_pkg::STATUS_NOMATCH;
                  res_slot_in   = found_ff ? 4'(hit_slot_ff) : 4'd0;
                  res_pal_in    = found_ff & hit_taste_ff;
               end else if (found_ff) begin
                  res_status_in = ham_pkg::STATUS_PRESENT;
                  res_slot_in   = 4'(hit_slot_ff);
                  res_pal_in    = hit_taste_ff;
               end else if (!pm_wr_en) begin
                  res_status_in = ham_pkg::STATUS_FULL;
                  res_slot_in   = 4'd0;
                  res_pal_in    = 1'b0;
               end else begin
                  res_status_in = ham_pkg::STATUS_STORED;
                  res_slot_in   = 4'(count_ff);
                  res_pal_in    = taste_ff;
                  count_in      = count_ff + CW'(1);
                  row_in        = '0;
                  state_in      = S_TRAIN;
               end
            end
         end
         S_TRAIN: begin
            if (train_done) state_in = S_DONE;
         end
         S_PASS: begin
            if (rs_out_valid && rs_out_idx == RW'(NEURONS - 1)) state_in = S_PCHECK;
         end
         S_PCHECK: begin
            y_in = nxt_ff;
            if (nxt_ff == y_ff || itr_ff > {1'b0, max_iter_ff}) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = S_SEARCH;
            end else begin
               itr_in   = itr_ff + 9'd1;
               row_in   = '0;
               nxt_in   = '0;
               state_in = S_PASS;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_pal_in    = res_pal_ff;
               rsp_pat_in    = y_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_iter_ff   <= ham_pkg::MAX_ITER_RESET;
         count_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_iter_ff   <= max_iter_in;
         count_ff      <= count_in;
         chk_valid_ff  <= chk_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      taste_ff      <= taste_in;
      y_ff          <= y_in;
      nxt_ff        <= nxt_in;
      itr_ff        <= itr_in;
      idx_ff        <= idx_in;
      chk_slot_ff   <= chk_slot_in;
      found_ff      <= found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_taste_ff  <= hit_taste_in;
      row_ff        <= row_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pal_ff    <= res_pal_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pal_ff    <= rsp_pal_in;
      rsp_pat_ff    <= rsp_pat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(ham_pkg::RSP_TDATA_W - 5)'(rsp_pat_ff), rsp_pal_ff, rsp_slot_ff};

   ham_weight_mem #(.NEURONS(NEURONS)) u_weights (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (wm_rd_en),
      .rd_addr (row_ff[RW-1:0]),
      .rd_row  (wm_rd_row),
      .wr_en   (wm_wr_en),
      .wr_addr (pend_idx_ff),
      .wr_row  (wm_wr_row)
   );

   ham_pattern_mem #(.NEURONS(NEURONS), .MAX_PATTERNS(MAX_PATTERNS)) u_patterns (
      .clock   (clock),
      .rd_en   (pm_rd_en),
      .rd_addr (idx_ff[SW-1:0]),
      .rd_data (pm_rd_data),
      .wr_en   (pm_wr_en),
      .wr_addr (count_ff[SW-1:0]),
      .wr_data ({taste_ff, y_ff})
   );

   ham_row_sum #(.NEURONS(NEURONS)) u_row_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rs_in_valid),
      .in_idx    (pend_idx_ff),
      .in_row    (wm_rd_row),
      .state_vec (y_ff),
      .out_valid (rs_out_valid),
      .out_idx   (rs_out_idx),
      .out_bit   (rs_out_bit)
   );
endmodule

[hw/rtl/ham_weight_mem.sv]
// Weight matrix, one row of weights per entry; rows never written read as zero.
module ham_weight_mem #(
   parameter int NEURONS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [$clog2(NEURONS)-1:0]             rd_addr,
   output logic [NEURONS*ham_pkg::WEIGHT_W-1:0]   rd_row,
   input  logic                                   wr_en,
   input  logic [$clog2(NEURONS)-1:0]             wr_addr,
   input  logic [NEURONS*ham_pkg::WEIGHT_W-1:0]   wr_row
);
   localparam int ROW_W = NEURONS * ham_pkg::WEIGHT_W;

   logic [ROW_W-1:0] mem [NEURONS];
   logic [ROW_W-1:0] q_ff;
   logic             q_valid_ff;
   logic [NEURONS-1:0] row_valid_ff;

   // row valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         q_valid_ff   <= 1'b0;
      end else begin
         if (wr_en) row_valid_ff[wr_addr] <= 1'b1;
         if (rd_en) q_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_row;
      if (rd_en) q_ff <= mem[rd_addr];
   end

   assign rd_row = q_valid_ff ? q_ff : '0;
endmodule

[hw/rtl/ham_pattern_mem.sv]
// Stored patterns with their palatability bit in the top bit.
module ham_pattern_mem #(
   parameter int NEURONS      = 64,
   parameter int MAX_PATTERNS = 16
) (
   input  logic                                            clock,
   input  logic                                            rd_en,
   input  logic [(MAX_PATTERNS > 1 ? $clog2(MAX_PATTERNS) : 1)-1:0] rd_addr,
   output logic [NEURONS:0]                                rd_data,
   input  logic                                            wr_en,
   input  logic [(MAX_PATTERNS > 1 ? $clog2(MAX_PATTERNS) : 1)-1:0] wr_addr,
   input  logic [NEURONS:0]                                wr_data
);
   logic [NEURONS:0] mem [MAX_PATTERNS];
   logic [NEURONS:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) q_ff <= mem[rd_addr];
   end

   assign rd_data = q_ff;
endmodule

[hw/rtl/ham_row_sum.sv]
// Two-stage weighted sum of one row against the current state; emits whether the sum is positive.
module ham_row_sum #(
   parameter int NEURONS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [$clog2(NEURONS)-1:0]             in_idx,
   input  logic [NEURONS*ham_pkg::WEIGHT_W-1:0]   in_row,
   input  logic [NEURONS-1:0]                     state_vec,
   output logic                                   out_valid,
   output logic [$clog2(NEURONS)-1:0]             out_idx,
   output logic                                   out_bit
);
   localparam int WW     = ham_pkg::WEIGHT_W;
   localparam int RW     = $clog2(NEURONS);
   localparam int GROUPS = (NEURONS + 7) / 8;
   localparam int GW     = WW + 4;
   localparam int SUMW   = GW + 4;

   logic signed [GW-1:0] grp_in [GROUPS];
   logic signed [GW-1:0] grp_ff [GROUPS];
   logic                 s1_valid_ff;
   logic [RW-1:0]        s1_idx_ff;
   logic signed [SUMW-1:0] total;
   logic                 out_valid_ff;
   logic [RW-1:0]        out_idx_ff;
   logic                 out_bit_ff;

   // first stage: partial sums over groups of eight neurons
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int t = 0; t < 8; t++) begin
            if (g * 8 + t < NEURONS) begin
               if (state_vec[g*8+t])
                  grp_in[g] = grp_in[g] + GW'(signed'(in_row[(g*8+t)*WW +: WW]));
               else
                  grp_in[g] = grp_in[g] - GW'(signed'(in_row[(g*8+t)*WW +: WW]));
            end
         end
      end
   end

   // second stage: sum of the groups
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) total = total + SUMW'(grp_ff[g]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) grp_ff[g] <= grp_in[g];
      s1_idx_ff  <= in_idx;
      out_idx_ff <= s1_idx_ff;
      out_bit_ff <= total > 0;
   end

   assign out_valid = out_valid_ff;
   assign out_idx   = out_idx_ff;
   assign out_bit   = out_bit_ff;
endmodule
